// File: src/parity_grouped_sorter_macros.svh
// Assertion macros for the parity-grouped sorter.
// Used by parity_grouped_sorter; relies on clk and rst in the including scope.
`ifndef PARITY_GROUPED_SORTER_MACROS_SVH
`define PARITY_GROUPED_SORTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PGS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pgs assertion failed");
`define PGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pgs assertion failed");
`else
`define PGS_ASSERT_IMPL(lbl, ante, cons)
`define PGS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/pgs_pkg.sv
// Shared types and key helpers for the parity-grouped sorter.
// No dependencies; used by pgs_cell and parity_grouped_sorter.
package pgs_pkg;

  localparam int WORD_W = 32;
  localparam int KEY_W  = WORD_W + 1;
  localparam logic [WORD_W-1:0] SIGN_FLIP = {1'b1, {(WORD_W-1){1'b0}}};

  typedef logic signed [WORD_W-1:0] word_t;
  // Sort key: parity above the sign-flipped value, so an unsigned compare
  // gives even values first, each group in ascending signed order.
  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

  function automatic key_t make_key(input word_t v);
    make_key = {v[0], v ^ SIGN_FLIP};
  endfunction

  function automatic word_t key_value(input key_t k);
    key_value = word_t'(k[WORD_W-1:0] ^ SIGN_FLIP);
  endfunction

endpackage

// File: src/pgs_cell.sv
// One cell of the insertion chain: keeps the smaller key, passes the larger on.
// Depends on pgs_pkg.
module pgs_cell (
  input  logic              clk,
  input  logic              rst,
  input  pgs_pkg::cell_ctrl_t ctrl,
  input  logic              in_valid,
  input  pgs_pkg::key_t     in_key,
  input  logic              nb_full,
  input  pgs_pkg::key_t     nb_key,
  output logic              full,
  output pgs_pkg::key_t     key,
  output logic              pass_valid,
  output pgs_pkg::key_t     pass_key
);
  import pgs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      full       <= 1'b0;
      pass_valid <= 1'b0;
    end else if (ctrl.shift) begin
      // Drain: take the right-hand neighbour's contents.
      full       <= nb_full;
      key        <= nb_key;
      pass_valid <= 1'b0;
    end else begin
      pass_valid <= 1'b0;
      if (in_valid) begin
        if (!full) begin
          full <= 1'b1;
          key  <= in_key;
        end else if (in_key < key) begin
          key        <= in_key;
          pass_valid <= 1'b1;
          pass_key   <= key;
        end else begin
          pass_valid <= 1'b1;
          pass_key   <= in_key;
        end
      end
    end
  end

endmodule

// File: src/parity_grouped_sorter.sv
// Top level of the parity-grouped sorter: control and the chain of sort cells.
// Depends on pgs_pkg, pgs_cell and parity_grouped_sorter_macros.svh.
//
// Usage: a list is loaded one element per transfer; a transfer happens at a
// clock edge where start is high and busy is low. During loading busy stays
// low, so one element can be taken in every cycle. last_in marks the final
// element. Each element enters a chain of MAX_ELEMENTS cells and ripples one
// cell per cycle to its sorted place, even values before odd ones.
// After the final element busy rises while the chain settles, then stays
// high while the n stored elements are shifted out of the head cell, one
// result per cycle, each marked by result_strobe for one cycle.
// last_out marks the final result; overflow is set on every result of a list
// that had elements dropped beyond MAX_ELEMENTS. Reset empties the chain and
// returns to loading. The receiver cannot stall: results are never held.
module parity_grouped_sorter #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pgs_pkg::word_t value,
  input  logic           last_in,
  output logic           result_strobe,
  output pgs_pkg::word_t sorted_value,
  output logic           last_out,
  output logic           overflow
);
  import pgs_pkg::*;
  `include "parity_grouped_sorter_macros.svh"

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int TMR_W = $clog2(MAX_ELEMENTS);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SETTLE = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  logic [TMR_W-1:0] timer;
  logic             dropped;
  logic             inj_valid;
  key_t             inj_key;
  logic             accept;
  cell_ctrl_t       ctrl;

  logic             cell_full  [MAX_ELEMENTS];
  key_t             cell_key   [MAX_ELEMENTS];
  logic             cell_pass  [MAX_ELEMENTS];
  key_t             cell_pkey  [MAX_ELEMENTS];

  assign busy       = (state != ST_LOAD);
  assign accept     = start && !busy;
  assign ctrl.shift = (state == ST_DRAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      timer         <= '0;
      dropped       <= 1'b0;
      inj_valid     <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      inj_valid     <= 1'b0;
      result_strobe <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (count < CNT_W'(MAX_ELEMENTS)) begin
              inj_valid <= 1'b1;
              inj_key   <= make_key(value);
              count     <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (last_in) begin
              state <= ST_SETTLE;
              timer <= TMR_W'(MAX_ELEMENTS - 1);
            end
          end
        end
        ST_SETTLE: begin
          // The newest element may still have to travel the whole chain.
          if (timer == '0) begin
            state <= ST_DRAIN;
          end else begin
            timer <= timer - 1'b1;
          end
        end
        ST_DRAIN: begin
          result_strobe <= 1'b1;
          sorted_value  <= key_value(cell_key[0]);
          last_out      <= (count == CNT_W'(1));
          overflow      <= dropped;
          count         <= count - 1'b1;
          if (count == CNT_W'(1)) begin
            state   <= ST_LOAD;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_chain
    logic in_valid_c;
    key_t in_key_c;
    logic nb_full_c;
    key_t nb_key_c;

    if (i == 0) begin : g_head
      assign in_valid_c = inj_valid;
      assign in_key_c   = inj_key;
    end else begin : g_body
      assign in_valid_c = cell_pass[i-1];
      assign in_key_c   = cell_pkey[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign nb_full_c = 1'b0;
      assign nb_key_c  = '0;
    end else begin : g_inner
      assign nb_full_c = cell_full[i+1];
      assign nb_key_c  = cell_key[i+1];
    end

    pgs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .in_valid   (in_valid_c),
      .in_key     (in_key_c),
      .nb_full    (nb_full_c),
      .nb_key     (nb_key_c),
      .full       (cell_full[i]),
      .key        (cell_key[i]),
      .pass_valid (cell_pass[i]),
      .pass_key   (cell_pkey[i])
    );
  end

  `PGS_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(MAX_ELEMENTS))
  `PGS_ASSERT_IMPL(a_tail_never_spills, 1'b1, !cell_pass[MAX_ELEMENTS-1])
  `PGS_ASSERT_NEXT(a_drain_strobes, state == ST_DRAIN, result_strobe)
  `PGS_ASSERT_NEXT(a_strobe_only_drain, state != ST_DRAIN, !result_strobe)
  `PGS_ASSERT_IMPL(a_drain_head_full, state == ST_DRAIN, cell_full[0])
  `PGS_ASSERT_NEXT(a_busy_after_last, accept && last_in, busy)

endmodule
